/* rtl/icc_pkg.sv */
// Shared types and constants of the iteration count colormap unit.
package icc_pkg;

    localparam int COUNT_W     = 8;
    localparam int COLOR_W     = 8;
    localparam int Q_W         = 32;
    localparam int SCALE_W     = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd60;

    // 9*255, 15*255 and 2*8.5*255 (blue drops one more bit at the end)
    localparam logic [SCALE_W-1:0] RED_SCALE     = 13'd2295;
    localparam logic [SCALE_W-1:0] GREEN_SCALE   = 13'd3825;
    localparam logic [SCALE_W-1:0] BLUE_SCALE_X2 = 13'd4335;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               zero;
    } t_item;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_tag;

endpackage

/* rtl/icc_front.sv */
// Front end: accepts counts and classifies the cases with an all-zero color.
module icc_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [icc_pkg::COUNT_W-1:0] i_iteration_count,
    input  logic [icc_pkg::COUNT_W-1:0] i_max_iterations,
    input  logic                        i_full,
    output logic                        o_push,
    output icc_pkg::t_item              o_item,
    output logic [icc_pkg::COUNT_W-1:0] o_bound
);
    import icc_pkg::*;

    // a zero bound behaves as one
    assign o_bound = (i_max_iterations == '0) ? COUNT_W'(1) : i_max_iterations;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // t = 0 or t = 1 (count at or above the bound) give black
    assign o_item.count = i_iteration_count;
    assign o_item.zero  = (i_iteration_count == '0) || (i_iteration_count >= o_bound);

endmodule

/* rtl/icc_fifo.sv */
// Short queue between the front end and the arithmetic back end.
module icc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  icc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output icc_pkg::t_item o_item
);
    import icc_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

/* rtl/icc_div.sv */
// Pipelined restoring divider: one quotient bit of count * 2^F / bound per stage.
module icc_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  icc_pkg::t_tag               i_tag,
    input  logic [icc_pkg::COUNT_W-1:0] i_count,
    input  logic [icc_pkg::COUNT_W-1:0] i_bound,
    output icc_pkg::t_tag               o_tag,
    output logic [FRACTION_BITS-1:0]    o_quo
);
    import icc_pkg::*;

    t_tag                     r_tag [FRACTION_BITS];
    logic [COUNT_W-1:0]       r_rem [FRACTION_BITS-1];
    logic [FRACTION_BITS-1:0] r_quo [FRACTION_BITS];

    genvar s;
    generate
        for (s = 0; s < FRACTION_BITS; s++) begin : g_stage
            t_tag                     w_tag_in;
            logic [COUNT_W-1:0]       w_rem_in;
            logic [FRACTION_BITS-1:0] w_quo_in;
            logic [COUNT_W:0]         w_rem2;
            logic                     w_ge;
            logic [COUNT_W:0]         w_diff;

            if (s == 0) begin : g_first
                assign w_tag_in = i_tag;
                assign w_rem_in = i_count;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_tag_in = r_tag[s-1];
                assign w_rem_in = r_rem[s-1];
                assign w_quo_in = r_quo[s-1];
            end

            // remainder stays below the bound, so the doubled value fits in 9 bits
            assign w_rem2 = {w_rem_in, 1'b0};
            assign w_ge   = (w_rem2 >= {1'b0, i_bound});
            assign w_diff = w_rem2 - {1'b0, i_bound};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[s] <= '0;
                end else if (i_en) begin
                    r_tag[s] <= w_tag_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[s] <= {w_quo_in[FRACTION_BITS-2:0], w_ge};
                end
            end

            if (s < FRACTION_BITS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[s] <= w_ge ? w_diff[COUNT_W-1:0] : w_rem2[COUNT_W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign o_tag = r_tag[FRACTION_BITS-1];
    assign o_quo = r_quo[FRACTION_BITS-1];

endmodule

/* rtl/icc_back.sv */
// Back end: divider, polynomial product pipeline and output register.
module icc_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    output logic                        o_pop,
    input  icc_pkg::t_item              i_item,
    input  logic [icc_pkg::COUNT_W-1:0] i_bound,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [icc_pkg::COLOR_W-1:0] o_red,
    output logic [icc_pkg::COLOR_W-1:0] o_green,
    output logic [icc_pkg::COLOR_W-1:0] o_blue
);
    import icc_pkg::*;

    localparam int SHIFT = Q_W - FRACTION_BITS;
    localparam int PW    = 2 * Q_W;
    localparam int SW    = SCALE_W + Q_W;

    logic w_en;
    t_tag w_div_tag;
    logic [FRACTION_BITS-1:0] w_t;
    logic [FRACTION_BITS:0]   w_u;

    // widened operands
    t_tag             r_w_tag;
    logic [Q_W-1:0]   r_w_tq, r_w_uq;
    // squares
    t_tag             r_a_tag;
    logic [Q_W-1:0]   r_a_tq, r_a_uq, r_a_t2, r_a_u2;
    // cubes and green product
    t_tag             r_b_tag;
    logic [Q_W-1:0]   r_b_tq, r_b_uq, r_b_t3, r_b_u3, r_b_pg;
    // red and blue products
    t_tag             r_c_tag;
    logic [Q_W-1:0]   r_c_pr, r_c_pg, r_c_pb;
    // output
    logic             r_out_vld;
    logic [COLOR_W-1:0] r_red, r_green, r_blue;

    logic [PW-1:0] w_a_t2, w_a_u2, w_b_t3, w_b_u3, w_b_pg, w_c_pr, w_c_pb;
    logic [SW-1:0] w_sr, w_sg, w_sb;

    // whole pipeline advances unless a finished result is held
    assign w_en  = !r_out_vld || i_ready;
    assign o_pop = w_en && i_avail;

    icc_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (t_tag'{vld: i_avail, zero: i_item.zero}),
        .i_count (i_item.count),
        .i_bound (i_bound),
        .o_tag   (w_div_tag),
        .o_quo   (w_t)
    );

    assign w_u = ((FRACTION_BITS + 1)'(1) << FRACTION_BITS) - {1'b0, w_t};

    assign w_a_t2 = PW'(r_w_tq) * PW'(r_w_tq);
    assign w_a_u2 = PW'(r_w_uq) * PW'(r_w_uq);
    assign w_b_t3 = PW'(r_a_t2) * PW'(r_a_tq);
    assign w_b_u3 = PW'(r_a_u2) * PW'(r_a_uq);
    assign w_b_pg = PW'(r_a_u2) * PW'(r_a_t2);
    assign w_c_pr = PW'(r_b_uq) * PW'(r_b_t3);
    assign w_c_pb = PW'(r_b_u3) * PW'(r_b_tq);

    assign w_sr = SW'(RED_SCALE)     * SW'(r_c_pr);
    assign w_sg = SW'(GREEN_SCALE)   * SW'(r_c_pg);
    assign w_sb = SW'(BLUE_SCALE_X2) * SW'(r_c_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_tag   <= '0;
            r_a_tag   <= '0;
            r_b_tag   <= '0;
            r_c_tag   <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_w_tag   <= w_div_tag;
            r_a_tag   <= r_w_tag;
            r_b_tag   <= r_a_tag;
            r_c_tag   <= r_b_tag;
            r_out_vld <= r_c_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w_tq <= Q_W'(w_t) << SHIFT;
            r_w_uq <= Q_W'(w_u[FRACTION_BITS-1:0]) << SHIFT;

            r_a_tq <= r_w_tq;
            r_a_uq <= r_w_uq;
            r_a_t2 <= w_a_t2[PW-1:Q_W];
            r_a_u2 <= w_a_u2[PW-1:Q_W];

            r_b_tq <= r_a_tq;
            r_b_uq <= r_a_uq;
            r_b_t3 <= w_b_t3[PW-1:Q_W];
            r_b_u3 <= w_b_u3[PW-1:Q_W];
            r_b_pg <= w_b_pg[PW-1:Q_W];

            r_c_pr <= w_c_pr[PW-1:Q_W];
            r_c_pg <= r_b_pg;
            r_c_pb <= w_c_pb[PW-1:Q_W];

            // force black where t is zero or one
            if (r_c_tag.zero) begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end else begin
                r_red   <= w_sr[Q_W+COLOR_W-1:Q_W];
                r_green <= w_sg[Q_W+COLOR_W-1:Q_W];
                r_blue  <= w_sb[Q_W+COLOR_W:Q_W+1];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

/* rtl/iteration_count_colormap_unit.sv */
// Top level of the iteration count colormap unit.
//
// Maps one escape-iteration count per pixel to an RGB byte triple using
// Bernstein-style polynomials of t = count / max_iterations.
// Input channel: i_valid / o_ready with i_iteration_count; a transfer
// happens on a rising edge with both high.
// Output channel: o_valid / i_ready with o_red, o_green, o_blue.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into max_iterations on
// the same edge; write it only while no pixel is in flight.
// Pipeline: from input transfer to o_valid a pixel passes the queue, the
// one-bit-per-stage divider, the widening stage, three product stages and
// the output register.
// Throughput: one pixel per cycle while the receiver takes results.
// While o_valid is high and i_ready is low the back pipeline holds; the
// four-entry queue keeps taking pixels until it fills, then o_ready drops.
// Reset: synchronous active-low i_rst_n empties the queue and pipeline
// and sets max_iterations to 60.
module iteration_count_colormap_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [icc_pkg::COUNT_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [icc_pkg::COUNT_W-1:0] i_iteration_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [icc_pkg::COLOR_W-1:0] o_red,
    output logic [icc_pkg::COLOR_W-1:0] o_green,
    output logic [icc_pkg::COLOR_W-1:0] o_blue
);
    import icc_pkg::*;

    logic [COUNT_W-1:0] r_max_iter;
    logic [COUNT_W-1:0] w_bound;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_avail;
    t_item              w_in_item;
    t_item              w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_iter <= i_cfg_wr_data;
        end
    end

    icc_front u_front (
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_iteration_count (i_iteration_count),
        .i_max_iterations  (r_max_iter),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_item            (w_in_item),
        .o_bound           (w_bound)
    );

    icc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_q_item)
    );

    icc_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .o_pop   (w_pop),
        .i_item  (w_q_item),
        .i_bound (w_bound),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule
